// ===== hdl/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg
// Types, character codes and helper functions for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX0   = 3'd2,
    PH_HEX1   = 3'd3,
    PH_OCT1   = 3'd4,
    PH_OCT2   = 3'd5
  } phase_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [7:0] BYTE_LF   = 8'd10;
  localparam logic [7:0] BYTE_CR   = 8'd13;
  localparam logic [7:0] BYTE_TAB  = 8'd9;
  localparam logic [7:0] BYTE_ESC  = 8'd27;

  localparam int QDEPTH = 4;

  // one result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } esd_res_t;

  // results of one input item, in order
  typedef struct packed {
    logic [1:0] cnt;
    esd_res_t   r0;
    esd_res_t   r1;
  } esd_push_t;

  // bit 4 set when c is a hex digit, low bits its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
        d = c - CH_0;
        hex_digit = {1'b1, d[3:0]};
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA + 8'd10;
        hex_digit = {1'b1, d[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 8'd10;
        hex_digit = {1'b1, d[3:0]};
      end else begin
        hex_digit = 5'd0;
      end
    end
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    is_octal = (c >= CH_0) && (c <= CH_7);
  endfunction

endpackage

// ===== hdl/esd_if.sv =====
// ----------------------------------------------------------------------------
// esd_in_if / esd_out_if
// Valid/ready channels for characters in and decoded bytes out.
// ----------------------------------------------------------------------------
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

// ===== hdl/esd_decode.sv =====
// ----------------------------------------------------------------------------
// esd_decode
// Escape parser: phase and pending value registers, up to two results per
// character.
// ----------------------------------------------------------------------------
module esd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take_i,
  input  logic [7:0]        char_i,
  input  logic              eos_i,
  output esd_pkg::esd_push_t push_o
);

  esd_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]      val_r, val_nxt;

  logic       pre_v, main_v, post_v;
  logic [7:0] pre_b, main_b, post_b;
  logic [4:0] hx;
  logic       oc;
  logic [1:0] n;
  esd_pkg::esd_res_t r0, r1;

  always_comb begin
    hx        = esd_pkg::hex_digit(char_i);
    oc        = esd_pkg::is_octal(char_i);
    pre_v     = 1'b0;
    pre_b     = {2'b00, val_r};
    main_v    = 1'b0;
    main_b    = char_i;
    post_v    = 1'b0;
    post_b    = 8'd0;
    phase_nxt = esd_pkg::PH_NORMAL;
    val_nxt   = val_r;

    unique case (phase_r)
      esd_pkg::PH_ESC: begin
        unique case (char_i)
          esd_pkg::CH_BSLASH, esd_pkg::CH_DQUOTE: main_v = 1'b1;
          esd_pkg::CH_N: begin
            main_v = 1'b1;
            main_b = esd_pkg::BYTE_LF;
          end
          esd_pkg::CH_R: begin
            main_v = 1'b1;
            main_b = esd_pkg::BYTE_CR;
          end
          esd_pkg::CH_T: begin
            main_v = 1'b1;
            main_b = esd_pkg::BYTE_TAB;
          end
          esd_pkg::CH_E: begin
            main_v = 1'b1;
            main_b = esd_pkg::BYTE_ESC;
          end
          esd_pkg::CH_X: phase_nxt = esd_pkg::PH_HEX0;
          default: begin
            if (oc) begin
              val_nxt   = {3'b000, char_i[2:0]};
              phase_nxt = esd_pkg::PH_OCT1;
            end else begin
              main_v = 1'b1;
            end
          end
        endcase
      end
      esd_pkg::PH_HEX0: begin
        if (hx[4]) begin
          val_nxt   = {2'b00, hx[3:0]};
          phase_nxt = esd_pkg::PH_HEX1;
        end else if (char_i == esd_pkg::CH_BSLASH) begin
          phase_nxt = esd_pkg::PH_ESC;
        end else begin
          main_v = 1'b1;
        end
      end
      esd_pkg::PH_HEX1: begin
        if (hx[4]) begin
          main_v = 1'b1;
          main_b = {val_r[3:0], hx[3:0]};
        end else begin
          pre_v = 1'b1;
          if (char_i == esd_pkg::CH_BSLASH) phase_nxt = esd_pkg::PH_ESC;
          else main_v = 1'b1;
        end
      end
      esd_pkg::PH_OCT1: begin
        if (oc) begin
          val_nxt   = {val_r[2:0], char_i[2:0]};
          phase_nxt = esd_pkg::PH_OCT2;
        end else begin
          pre_v = 1'b1;
          if (char_i == esd_pkg::CH_BSLASH) phase_nxt = esd_pkg::PH_ESC;
          else main_v = 1'b1;
        end
      end
      esd_pkg::PH_OCT2: begin
        if (oc) begin
          main_v = 1'b1;
          main_b = {val_r[4:0], char_i[2:0]};
        end else begin
          pre_v = 1'b1;
          if (char_i == esd_pkg::CH_BSLASH) phase_nxt = esd_pkg::PH_ESC;
          else main_v = 1'b1;
        end
      end
      default: begin
        if (char_i == esd_pkg::CH_BSLASH) phase_nxt = esd_pkg::PH_ESC;
        else main_v = 1'b1;
      end
    endcase

    // end of string flushes a partial value and returns to normal
    if (eos_i) begin
      if (phase_nxt == esd_pkg::PH_HEX1 || phase_nxt == esd_pkg::PH_OCT1 ||
          phase_nxt == esd_pkg::PH_OCT2) begin
        post_v = 1'b1;
        post_b = {2'b00, val_nxt};
      end
      phase_nxt = esd_pkg::PH_NORMAL;
      val_nxt   = 6'd0;
    end

    // pack in order: pending flush, character byte, end flush
    r0 = '{out_byte: 8'd0, out_valid: 1'b0, out_last: 1'b0};
    r1 = '{out_byte: 8'd0, out_valid: 1'b0, out_last: 1'b0};
    if (pre_v) begin
      r0 = '{out_byte: pre_b, out_valid: 1'b1, out_last: 1'b0};
      r1 = '{out_byte: main_v ? main_b : post_b, out_valid: 1'b1, out_last: 1'b0};
    end else if (main_v) begin
      r0 = '{out_byte: main_b, out_valid: 1'b1, out_last: 1'b0};
      r1 = '{out_byte: post_b, out_valid: 1'b1, out_last: 1'b0};
    end else if (post_v) begin
      r0 = '{out_byte: post_b, out_valid: 1'b1, out_last: 1'b0};
    end
    n = {1'b0, pre_v} + {1'b0, main_v} + {1'b0, post_v};
    if (eos_i) begin
      if (n == 2'd2) begin
        r1.out_last = 1'b1;
      end else begin
        n           = 2'd1;
        r0.out_last = 1'b1;
      end
    end

    push_o.cnt = take_i ? n : 2'd0;
    push_o.r0  = r0;
    push_o.r1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= esd_pkg::PH_NORMAL;
      val_r   <= 6'd0;
    end else if (take_i) begin
      phase_r <= phase_nxt;
      val_r   <= val_nxt;
    end
  end

endmodule

// ===== hdl/esd_outq.sv =====
// ----------------------------------------------------------------------------
// esd_outq
// Four-entry result queue: takes up to two results a cycle, gives one when popped.
// ----------------------------------------------------------------------------
module esd_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  esd_pkg::esd_push_t  push_i,
  input  logic                pop_i,
  output logic                room_o,
  output logic                head_vld_o,
  output esd_pkg::esd_res_t   head_o
);

  localparam int AW = $clog2(esd_pkg::QDEPTH);

  esd_pkg::esd_res_t  mem_r [esd_pkg::QDEPTH];
  logic [AW-1:0]      wr_r, wr_nxt;
  logic [AW-1:0]      rd_r, rd_nxt;
  logic [AW:0]        cnt_r, cnt_nxt;
  logic               pop;

  assign room_o     = cnt_r <= (AW + 1)'(esd_pkg::QDEPTH - 2);
  assign head_vld_o = cnt_r != '0;
  assign head_o     = mem_r[rd_r];
  assign pop        = pop_i && head_vld_o;

  always_comb begin
    wr_nxt  = wr_r + AW'(push_i.cnt);
    rd_nxt  = rd_r + AW'(pop);
    cnt_nxt = cnt_r + (AW + 1)'(push_i.cnt) - (AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) mem_r[wr_r] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_r[wr_r + AW'(1)] <= push_i.r1;
  end

endmodule

// ===== hdl/escape_sequence_byte_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_byte_decoder
// Decodes C-style escaped text, one character per transaction, into bytes.
// ----------------------------------------------------------------------------
// Takes one character per cycle while input ready is high. A character enters
// an input register and is decoded from there once the queue has room. Its
// results, at most two and possibly none, land in a four-entry result queue at
// the next edge, and results are offered straight from the queue head. The
// output side drains one result per cycle while output ready is high. A
// character that yields two results costs one extra output transaction. Such a
// character is a pending hex or octal value followed by a plain character.
// Input ready drops when a character waits in the input register and more than
// two results wait in the queue. Every end of string transaction yields a
// result marked out_last, with out_valid low when it carries no byte.
module escape_sequence_byte_decoder (
  input  logic       clk,
  input  logic       rst_n,
  esd_in_if.sink     in_ch,
  esd_out_if.source  out_ch
);

  logic                in_vld_r;
  logic [7:0]          char_r;
  logic                eos_r;
  logic                room;
  logic                adv;
  esd_pkg::esd_push_t  push;
  esd_pkg::esd_res_t   head;
  logic                head_vld;

  assign adv         = in_vld_r && room;
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      char_r <= in_ch.char_code;
      eos_r  <= in_ch.end_of_string;
    end
  end

  esd_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .take_i (adv),
    .char_i (char_r),
    .eos_i  (eos_r),
    .push_o (push)
  );

  esd_outq u_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .pop_i      (out_ch.ready),
    .room_o     (room),
    .head_vld_o (head_vld),
    .head_o     (head)
  );

  assign out_ch.valid     = head_vld;
  assign out_ch.out_byte  = head.out_byte;
  assign out_ch.out_valid = head.out_valid;
  assign out_ch.out_last  = head.out_last;

endmodule

// ===== hdl/esd_checker.sv =====
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks for the escape sequence decoder, bound to the top level.
// ----------------------------------------------------------------------------
module esd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_vld,
  input logic       out_rdy,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       out_last
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_rdy |=> out_vld && $stable(out_byte) && $stable(out_valid) &&
                            $stable(out_last))
    else $error("result changed while stalled");

  // nothing to deliver right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld && in_ready)
    else $error("not empty after reset");

  // an empty result only closes a string
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_valid |-> out_last && out_byte == 8'd0)
    else $error("empty result not marked last");

  // input stalls only while results wait
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_vld)
    else $error("input stalled with empty output");

  // a waiting character never blocks longer than the output is stalled
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready && out_rdy |=> ##1 in_ready || out_vld)
    else $error("input stuck");

endmodule

bind escape_sequence_byte_decoder esd_checker u_esd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_vld   (out_ch.valid),
  .out_rdy   (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_valid (out_ch.out_valid),
  .out_last  (out_ch.out_last)
);

// ===== sim/escape_sequence_byte_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_sequence_byte_decoder_tb
// Drives escaped character strings into the decoder and checks every decoded
// byte, its valid flag and its end-of-string mark against an in-bench decoder.
// Directed strings come first: every escape, hex and octal edge cases, and
// strings that end inside an escape. Random strings follow. The sender idles
// in bursts, the receiver stalls on its own pattern and holds off once long
// enough for the decoder to fill up and stall its input.
// ----------------------------------------------------------------------------
module escape_sequence_byte_decoder_tb;

  localparam int CHAR_TARGET  = 1900;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 90;
  localparam int TAIL_CYCLES  = 8;
  localparam int PRINT_LIMIT  = 50;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } char_item_t;

  typedef enum {TK_PLAIN, TK_SIMPLE, TK_HEX, TK_OCTAL, TK_UNKNOWN, TK_NOISE} token_kind_t;
  typedef enum {RX_FREE, RX_COIN, RX_PACED, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  esd_in_if  in_bus ();
  esd_out_if out_bus ();

  escape_sequence_byte_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  char_item_t         char_queue[$];
  logic [7:0]         text_buf[$];
  esd_pkg::esd_res_t  expected_octets[$];

  esd_pkg::phase_t    esc_phase;
  logic [8:0]         esc_value;
  esd_pkg::esd_res_t  held;
  logic               held_ok;

  int mismatch_count;
  int chars_total;
  int chars_accepted;
  int idle_cycles;

  // ---------------------------------------------------------------- stimulus

  task automatic add_item(input logic [7:0] c, input logic eos);
    char_item_t item;
    item.char_code     = c;
    item.end_of_string = eos;
    char_queue.push_back(item);
  endtask

  task automatic add_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) add_item(s[i], close && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] printable_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == esd_pkg::CH_BSLASH) c = esd_pkg::CH_UA;
    return c;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'(esd_pkg::CH_0 + v);
    else if (v < 16) return 8'(esd_pkg::CH_LA + v - 10);
    else return 8'(esd_pkg::CH_UA + v - 16);
  endfunction

  task automatic add_token();
    token_kind_t kind;
    int pick;
    int digits;
    pick = $urandom_range(0, 99);
    kind = pick < 30 ? TK_PLAIN : pick < 45 ? TK_SIMPLE : pick < 65 ? TK_HEX :
           pick < 85 ? TK_OCTAL : pick < 90 ? TK_UNKNOWN : TK_NOISE;
    if (kind != TK_PLAIN && kind != TK_NOISE) text_buf.push_back(esd_pkg::CH_BSLASH);
    case (kind)
      TK_PLAIN: text_buf.push_back(printable_char());
      TK_SIMPLE: begin
        case ($urandom_range(0, 5))
          0: text_buf.push_back(esd_pkg::CH_BSLASH);
          1: text_buf.push_back(esd_pkg::CH_DQUOTE);
          2: text_buf.push_back(esd_pkg::CH_N);
          3: text_buf.push_back(esd_pkg::CH_R);
          4: text_buf.push_back(esd_pkg::CH_T);
          default: text_buf.push_back(esd_pkg::CH_E);
        endcase
      end
      TK_HEX: begin
        text_buf.push_back(esd_pkg::CH_X);
        digits = $urandom_range(0, 2);
        repeat (digits) text_buf.push_back(rand_hex_char());
      end
      TK_OCTAL: begin
        digits = $urandom_range(1, 3);
        repeat (digits) text_buf.push_back(8'(esd_pkg::CH_0 + $urandom_range(0, 7)));
      end
      default: text_buf.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic add_random_string();
    int tokens;
    int mark;
    int keep;
    text_buf.delete();
    tokens = $urandom_range(1, 10);
    mark = 0;
    for (int k = 0; k < tokens; k++) begin
      mark = text_buf.size();
      add_token();
    end
    // end of string inside the final escape now and then
    if ($urandom_range(0, 3) == 0) begin
      keep = $urandom_range(mark + 1, text_buf.size());
      while (text_buf.size() > keep) void'(text_buf.pop_back());
    end
    foreach (text_buf[j]) add_item(text_buf[j], j == text_buf.size() - 1);
  endtask

  // --------------------------------------------------------------- predictor

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= esd_pkg::CH_0 && c <= esd_pkg::CH_9) return {1'b1, c[3:0]};
    else if (folded >= esd_pkg::CH_LA && folded <= esd_pkg::CH_LF)
      return {1'b1, folded[3:0] + 4'd9};
    else return 5'd0;
  endfunction

  task automatic emit_octet(input logic [7:0] b);
    if (held_ok) expected_octets.push_back(held);
    held.out_byte  = b;
    held.out_valid = 1'b1;
    held.out_last  = 1'b0;
    held_ok        = 1'b1;
  endtask

  task automatic predict_octets(input logic [7:0] c, input logic eos);
    logic [4:0] nib;
    logic       oct;
    logic       as_text;
    nib     = hex_nibble(c);
    oct     = (c >> 3) == (esd_pkg::CH_0 >> 3);
    as_text = 1'b0;
    held_ok = 1'b0;
    case (esc_phase)
      esd_pkg::PH_ESC: begin
        esc_phase = esd_pkg::PH_NORMAL;
        if (c == esd_pkg::CH_BSLASH || c == esd_pkg::CH_DQUOTE) emit_octet(c);
        else if (c == esd_pkg::CH_N) emit_octet(esd_pkg::BYTE_LF);
        else if (c == esd_pkg::CH_R) emit_octet(esd_pkg::BYTE_CR);
        else if (c == esd_pkg::CH_T) emit_octet(esd_pkg::BYTE_TAB);
        else if (c == esd_pkg::CH_E) emit_octet(esd_pkg::BYTE_ESC);
        else if (c == esd_pkg::CH_X) esc_phase = esd_pkg::PH_HEX0;
        else if (oct) begin
          esc_value = {6'd0, c[2:0]};
          esc_phase = esd_pkg::PH_OCT1;
        end else emit_octet(c);
      end
      esd_pkg::PH_HEX0: begin
        if (nib[4]) begin
          esc_value = {5'd0, nib[3:0]};
          esc_phase = esd_pkg::PH_HEX1;
        end else as_text = 1'b1;
      end
      esd_pkg::PH_HEX1: begin
        if (nib[4]) begin
          emit_octet({esc_value[3:0], nib[3:0]});
          esc_phase = esd_pkg::PH_NORMAL;
        end else begin
          emit_octet(esc_value[7:0]);
          as_text = 1'b1;
        end
      end
      esd_pkg::PH_OCT1: begin
        if (oct) begin
          esc_value = {esc_value[5:0], c[2:0]};
          esc_phase = esd_pkg::PH_OCT2;
        end else begin
          emit_octet(esc_value[7:0]);
          as_text = 1'b1;
        end
      end
      esd_pkg::PH_OCT2: begin
        if (oct) begin
          // third octal digit, only the low eight bits survive
          emit_octet({esc_value[4:0], c[2:0]});
          esc_phase = esd_pkg::PH_NORMAL;
        end else begin
          emit_octet(esc_value[7:0]);
          as_text = 1'b1;
        end
      end
      default: as_text = 1'b1;
    endcase
    if (as_text) begin
      if (c == esd_pkg::CH_BSLASH) esc_phase = esd_pkg::PH_ESC;
      else begin
        emit_octet(c);
        esc_phase = esd_pkg::PH_NORMAL;
      end
    end
    if (eos) begin
      if (esc_phase == esd_pkg::PH_HEX1 || esc_phase == esd_pkg::PH_OCT1 ||
          esc_phase == esd_pkg::PH_OCT2)
        emit_octet(esc_value[7:0]);
      if (!held_ok) begin
        held    = '0;
        held_ok = 1'b1;
      end
      held.out_last = 1'b1;
      esc_phase = esd_pkg::PH_NORMAL;
      esc_value = 9'd0;
    end
    if (held_ok) expected_octets.push_back(held);
  endtask

  // ------------------------------------------------------------------ driver

  int         burst_left;
  int         gap_left;
  int         hold_left;
  char_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_octets(in_bus.char_code, in_bus.end_of_string);
        chars_accepted++;
      end
      if (in_bus.valid && !in_bus.ready) begin
        // transaction still offered
      end else if (gap_left > 0 && hold_left == 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (char_queue.size() > 0) begin
        next_item = char_queue.pop_front();
        in_bus.char_code     <= next_item.char_code;
        in_bus.end_of_string <= next_item.end_of_string;
        in_bus.valid         <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int       hold_seen;
  logic     hold_done;
  rx_mode_t rx_mode;
  int       mode_left;
  int       pace;
  logic     take;

  // one long hold-off once enough characters went in
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
      hold_seen <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) hold_seen <= hold_seen + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && hold_seen >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      mode_left = 0;
      pace = 0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 200);
      end
      mode_left--;
      pace++;
      case (rx_mode)
        RX_FREE:  take = 1'b1;
        RX_COIN:  take = 1'($urandom_range(0, 1));
        RX_PACED: take = (pace % 4) == 0;
        default:  take = $urandom_range(0, 7) != 0;
      endcase
      out_bus.ready <= take && (hold_left == 0);
    end
  end

  // ----------------------------------------------------------------- checker

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %02h expected %02h", $time, what, got, want);
  endtask

  esd_pkg::esd_res_t want;

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_octets.size() == 0) begin
        note_mismatch("result with nothing pending, out_byte", out_bus.out_byte, 8'd0);
      end else begin
        want = expected_octets.pop_front();
        if (out_bus.out_byte !== want.out_byte)
          note_mismatch("out_byte", out_bus.out_byte, want.out_byte);
        if (out_bus.out_valid !== want.out_valid)
          note_mismatch("out_valid", {7'd0, out_bus.out_valid}, {7'd0, want.out_valid});
        if (out_bus.out_last !== want.out_last)
          note_mismatch("out_last", {7'd0, out_bus.out_last}, {7'd0, want.out_last});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, expected_octets.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------- main

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.char_code     = 8'd0;
    in_bus.end_of_string = 1'b0;
    out_bus.ready        = 1'b0;
    esc_phase            = esd_pkg::PH_NORMAL;
    esc_value            = 9'd0;
    held                 = '0;
    held_ok              = 1'b0;
    mismatch_count       = 0;
    chars_accepted       = 0;
    idle_cycles          = 0;
    burst_left           = 0;
    gap_left             = 0;

    // every simple escape
    add_text("\\\\\\\"\\n\\r\\t\\e", 1'b0);
    // two hex digits mixed case, hex with no digit, octal overflow
    add_text("\\xfF\\x\\777", 1'b0);
    // partial hex cut by a backslash, unknown escape on the top byte value
    add_text("\\x9\\", 1'b0);
    add_item(8'hFF, 1'b0);
    // partial octal cut by a zero byte, two-digit octal flushed at end of string
    add_text("\\5", 1'b0);
    add_item(8'h00, 1'b0);
    add_text("\\12", 1'b1);
    // end of string on a lone backslash, on a bare \x, on a partial hex value
    add_text("\\", 1'b1);
    add_text("\\x", 1'b1);
    add_text("\\xA", 1'b1);
    add_item(8'hFF, 1'b1);

    while (char_queue.size() < CHAR_TARGET) add_random_string();
    chars_total = char_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_accepted < chars_total) @(posedge clk);
    while (expected_octets.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/esd_pkg.sv
hdl/esd_if.sv
hdl/esd_decode.sv
hdl/esd_outq.sv
hdl/escape_sequence_byte_decoder.sv
hdl/esd_checker.sv
sim/escape_sequence_byte_decoder_tb.sv
